// File: rtl/mrr_pkg.sv
// Package for the Miller-Rabin round block: default width and shared types.
// No dependencies.
package mrr_pkg;
  localparam int unsigned NumBitsDefault = 64;

  // Payload of one input transfer and of one result transfer.
  typedef struct packed {
    logic [63:0] candidate;
    logic [63:0] witness;
  } mrr_req_t;

  typedef struct packed {
    logic passes;
  } mrr_rsp_t;

  typedef struct packed {
    logic load;       // take candidate and witness, start reduction
    logic mul_start;  // start a modular product
    logic mul_sel_sq; // 1: x*x into x, 0: see mul_acc
    logic mul_acc;    // 1: acc*sq into acc, 0: sq*sq into sq
    logic shift_e;    // shift exponent right by one
    logic strip_r;    // drop one trailing zero of r, count s
    logic acc_to_x;   // x <= acc
  } mrr_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic red_busy;
    logic trivial_pass;
    logic trivial_fail;
    logic r_even;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic s_more;     // j < s still
  } mrr_sts_t;
endpackage

// File: rtl/mrr_if.sv
// Valid/ready channel interface with a payload of parameter type.
// Depends on nothing.
interface mrr_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/miller_rabin_round_64.sv
// Top level of the Miller-Rabin round block: controller plus datapath.
// Depends on mrr_pkg, mrr_if, mrr_ctrl and mrr_datapath.
// One item is processed at a time. The modular multiplier is bit-serial, and the
// witness reduction, also bit-serial, is overlapped with the check of n-1.
// Trivial candidates finish without any modular product.
module miller_rabin_round_64 #(
  parameter int unsigned NUM_BITS = mrr_pkg::NumBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  mrr_if.sink   in_if,
  mrr_if.source out_if
);
  import mrr_pkg::*;

  mrr_cmd_t cmd;
  mrr_sts_t sts;

  mrr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .passes_o   (out_if.data.passes),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mrr_datapath #(.NumBits(NUM_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cand_i(in_if.data.candidate[NUM_BITS-1:0]),
    .wit_i (in_if.data.witness[NUM_BITS-1:0]),
    .cmd_i (cmd),
    .sts_o (sts)
  );
endmodule

// File: rtl/mrr_datapath.sv
// Datapath: operand registers, an interleaved modular multiplier (one bit per
// cycle), a bit-serial reduction of the witness and the round bookkeeping.
// Depends on mrr_pkg.
module mrr_datapath #(
  parameter int unsigned NumBits = mrr_pkg::NumBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NumBits-1:0]  cand_i,
  input  logic [NumBits-1:0]  wit_i,
  input  mrr_pkg::mrr_cmd_t   cmd_i,
  output mrr_pkg::mrr_sts_t   sts_o
);
  import mrr_pkg::*;
  localparam int unsigned CntW = $clog2(NumBits + 1);

  typedef enum logic [1:0] {
    DstAcc = 2'd0,
    DstSq  = 2'd1,
    DstX   = 2'd2
  } mul_dst_e;

  logic [NumBits-1:0] n_q, r_q, acc_q, sq_q, x_q;
  logic [CntW-1:0]    s_q, j_q;
  // multiplier
  logic               mbusy_q;
  logic [CntW-1:0]    mcnt_q;
  logic [NumBits-1:0] ma_q, mb_q, mp_q;
  mul_dst_e           mdst_q;
  // reduction: remainder of witness by n, one bit per cycle
  logic               rbusy_q;
  logic [CntW-1:0]    rcnt_q;
  logic [NumBits-1:0] rw_q, rr_q;

  logic [NumBits-1:0] nm1, dbl, dbl_add, red_next;
  logic [NumBits:0]   rsh;

  // (x + y) mod n for x, y < n
  function automatic logic [NumBits-1:0] add_mod(input logic [NumBits-1:0] x,
      input logic [NumBits-1:0] y, input logic [NumBits-1:0] m);
    logic [NumBits-1:0] gap;
    gap = m - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  assign nm1     = n_q - 1'b1;
  assign dbl     = add_mod(mp_q, mp_q, n_q);
  assign dbl_add = mb_q[NumBits-1] ? add_mod(dbl, ma_q, n_q) : dbl;
  assign rsh     = {rr_q, rw_q[NumBits-1]};
  assign red_next = (rsh >= {1'b0, n_q}) ? NumBits'(rsh - {1'b0, n_q})
                                         : rsh[NumBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      rbusy_q <= 1'b0;
    end else begin
      if (cmd_i.mul_start) mbusy_q <= 1'b1;
      else if (mbusy_q && mcnt_q == CntW'(NumBits - 1)) mbusy_q <= 1'b0;
      if (cmd_i.load) rbusy_q <= 1'b1;
      else if (rbusy_q && rcnt_q == CntW'(NumBits - 1)) rbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    // A new load restarts a reduction that may still run from a trivial item.
    if (cmd_i.load) begin
      n_q    <= cand_i;
      r_q    <= cand_i - 1'b1;
      s_q    <= '0;
      j_q    <= CntW'(1);
      acc_q  <= NumBits'(1);
      rw_q   <= wit_i;
      rr_q   <= '0;
      rcnt_q <= '0;
    end else if (rbusy_q) begin
      rr_q   <= red_next;
      rw_q   <= rw_q << 1;
      rcnt_q <= rcnt_q + 1'b1;
      if (rcnt_q == CntW'(NumBits - 1)) sq_q <= red_next;
    end
    if (cmd_i.strip_r) begin
      r_q <= r_q >> 1;
      s_q <= s_q + 1'b1;
    end
    if (cmd_i.shift_e) r_q <= r_q >> 1;
    if (cmd_i.acc_to_x) x_q <= acc_q;
    if (cmd_i.mul_start) begin
      mcnt_q <= '0;
      mp_q   <= '0;
      if (cmd_i.mul_sel_sq) begin
        ma_q <= x_q; mb_q <= x_q; mdst_q <= DstX; j_q <= j_q + 1'b1;
      end else if (cmd_i.mul_acc) begin
        ma_q <= acc_q; mb_q <= sq_q; mdst_q <= DstAcc;
      end else begin
        ma_q <= sq_q; mb_q <= sq_q; mdst_q <= DstSq;
      end
    end else if (mbusy_q) begin
      mp_q   <= dbl_add;
      mb_q   <= mb_q << 1;
      mcnt_q <= mcnt_q + 1'b1;
      if (mcnt_q == CntW'(NumBits - 1)) begin
        unique case (mdst_q)
          DstAcc:  acc_q <= dbl_add;
          DstSq:   sq_q  <= dbl_add;
          default: x_q   <= dbl_add;
        endcase
      end
    end
  end

  assign sts_o.mul_busy     = mbusy_q;
  assign sts_o.red_busy     = rbusy_q;
  assign sts_o.trivial_pass = (n_q == NumBits'(2)) || (n_q == NumBits'(3));
  assign sts_o.trivial_fail = (n_q <= NumBits'(1)) || !n_q[0];
  assign sts_o.r_even       = !r_q[0];
  assign sts_o.e_zero       = (r_q == '0);
  assign sts_o.e_lsb        = r_q[0];
  assign sts_o.x_one        = (x_q == NumBits'(1));
  assign sts_o.x_nm1        = (x_q == nm1);
  assign sts_o.s_more       = (j_q < s_q);
endmodule

// File: rtl/mrr_ctrl.sv
// Controller state machine sequencing one Miller-Rabin round.
// Depends on mrr_pkg.
module mrr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              passes_o,
  output mrr_pkg::mrr_cmd_t cmd_o,
  input  mrr_pkg::mrr_sts_t sts_i
);
  import mrr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_STRIP = 10'b0000000100,
    S_RED   = 10'b0000001000,
    S_POW   = 10'b0000010000,
    S_PWAIT = 10'b0000100000,
    S_SQ    = 10'b0001000000,
    S_TEST  = 10'b0010000000,
    S_XWAIT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   res_q, res_d, acc_step_q, acc_step_d;

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    acc_step_d = acc_step_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.trivial_pass) begin
          res_d = 1'b1; state_d = S_DONE;
        end else if (sts_i.trivial_fail) begin
          res_d = 1'b0; state_d = S_DONE;
        end else state_d = S_STRIP;
      end
      S_STRIP: if (sts_i.r_even) cmd_o.strip_r = 1'b1;
               else state_d = S_RED;
      S_RED: if (!sts_i.red_busy) state_d = S_POW;
      S_POW: begin
        // Each exponent bit: optional acc*sq, then sq*sq and shift.
        if (sts_i.e_zero) begin
          cmd_o.acc_to_x = 1'b1;
          state_d = S_TEST;
        end else if (sts_i.e_lsb && !acc_step_q) begin
          cmd_o.mul_start = 1'b1; cmd_o.mul_acc = 1'b1;
          acc_step_d = 1'b1; state_d = S_PWAIT;
        end else begin
          cmd_o.mul_start = 1'b1; cmd_o.shift_e = 1'b1;
          acc_step_d = 1'b0; state_d = S_PWAIT;
        end
      end
      S_PWAIT: if (!sts_i.mul_busy) state_d = S_POW;
      S_TEST: begin
        if (sts_i.x_one || sts_i.x_nm1) begin
          res_d = 1'b1; state_d = S_DONE;
        end else if (sts_i.s_more) state_d = S_SQ;
        else begin
          res_d = 1'b0; state_d = S_DONE;
        end
      end
      S_SQ: begin
        cmd_o.mul_start = 1'b1; cmd_o.mul_sel_sq = 1'b1;
        state_d = S_XWAIT;
      end
      S_XWAIT: if (!sts_i.mul_busy) begin
        priority if (sts_i.x_nm1) begin
          res_d = 1'b1; state_d = S_DONE;
        end else if (sts_i.x_one || !sts_i.s_more) begin
          res_d = 1'b0; state_d = S_DONE;
        end else state_d = S_SQ;
      end
      S_DONE: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_DONE);
  assign passes_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      acc_step_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_step_q <= acc_step_d;
    end
  end

  always_ff @(posedge clk_i) res_q <= res_d;
endmodule

// File: tb/tb_mrr_checker.sv
// Checker for the Miller-Rabin round block: watches both channels, predicts each verdict
// and compares it with the block's answer. Depends on nothing outside this file.
module tb_mrr_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [63:0]  candidate_i,
  input  logic [63:0]  witness_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic         passes_i,
  output int unsigned  pending_o,
  output int unsigned  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  bit verdicts_q[$];

  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] gap;
    gap = m - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  // Interleaved product, taking the multiplier from its top bit down.
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = add_mod(acc, acc, m);
      if (b[i]) acc = add_mod(acc, a, m);
    end
    return acc;
  endfunction

  function automatic bit round_passes(logic [63:0] n, logic [63:0] a);
    logic [63:0] r, x, sq, e, nm1;
    int unsigned s;
    if (n == 64'd2 || n == 64'd3) return 1'b1;
    if (n <= 64'd1 || !n[0]) return 1'b0;
    nm1 = n - 1;
    r = nm1;
    s = 0;
    while (!r[0]) begin
      r = r >> 1;
      s++;
    end
    x = 64'd1;
    sq = a % n;
    e = r;
    while (e != 0) begin
      if (e[0]) x = mul_mod(x, sq, n);
      sq = mul_mod(sq, sq, n);
      e = e >> 1;
    end
    if (x == 64'd1 || x == nm1) return 1'b1;
    for (int unsigned j = 1; j < s && x != nm1; j++) begin
      x = mul_mod(x, x, n);
      if (x == 64'd1) return 1'b0;
    end
    return x == nm1;
  endfunction

  assign pending_o = verdicts_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) verdicts_q.push_back(round_passes(candidate_i, witness_i));
      if (out_valid_i && out_ready_i) begin
        if (verdicts_q.size() == 0) begin
          $display("%0t: verdict %0b with no transfer waiting", $time, passes_i);
          errors_o <= errors_o + 1;
        end else begin
          want = verdicts_q.pop_front();
          if (want !== passes_i) begin
            $display("%0t: passes expected %0b actual %0b", $time, want, passes_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/tb_miller_rabin_round_64.sv
// Testbench top for miller_rabin_round_64: drives candidates and witnesses with random gaps
// and gives the verdict. Depends on mrr_pkg, mrr_if, the block and tb_mrr_checker.
module tb_miller_rabin_round_64;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] BigPrime = 64'hFFFF_FFFF_FFFF_FFC5;  // largest 64-bit prime

  logic clk_i;
  logic rst_ni;
  int unsigned pending, errors;

  mrr_if #(.T(mrr_pkg::mrr_req_t)) in_if (.clk_i(clk_i));
  mrr_if #(.T(mrr_pkg::mrr_rsp_t)) out_if (.clk_i(clk_i));

  miller_rabin_round_64 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  tb_mrr_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .candidate_i(in_if.data.candidate),
    .witness_i  (in_if.data.witness),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .passes_i   (out_if.data.passes),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Half the time no gap, else mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(0, 99) < 70);
      if (!out_if.ready) repeat (gap_len()) @(negedge clk_i);
    end
  end

  task automatic send(logic [63:0] n, logic [63:0] a);
    int unsigned idle;
    idle = gap_len();
    if (idle > 0) begin
      in_if.valid = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data = '{candidate: n, witness: a};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] n, a;
    in_if.valid = 1'b0;
    in_if.data = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Small and even candidates, whatever the witness.
    send(64'd0, 64'd5);
    send(64'd1, '1);
    send(64'd2, 64'd0);
    send(64'd3, '1);
    send(64'd4, 64'd3);
    send(64'hFFFF_FFFF_FFFF_FFFE, 64'd7);
    // Odd extremes and known primes.
    send('1, 64'd2);
    send(BigPrime, 64'd2);
    send(BigPrime, '1);
    send(BigPrime, 64'd0);
    send(BigPrime, BigPrime);
    send(BigPrime, BigPrime - 1);
    send(BigPrime, BigPrime + 1);
    send(BigPrime, 64'd1);
    send(64'd5, 64'd2);
    send(64'd7, 64'd14);
    // Composites, including strong pseudoprimes to base 2.
    send(64'd561, 64'd2);
    send(64'd2047, 64'd2);
    send(64'd2047, 64'd3);
    send(64'd3215031751, 64'd2);
    send(64'd9, 64'd8);
    send(64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555);

    for (int i = 0; i < 80; i++) begin
      n = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) n = n >> $urandom_range(1, 60);
      case ($urandom_range(0, 9))
        0: n = {n[63:1], 1'b0};
        1: n = BigPrime;
        default: n = {n[63:1], 1'b1};
      endcase
      a = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: a = n - 1;
        1: a = n + 1;
        2: a = n;
        default: ;
      endcase
      send(n, a);
    end
    in_if.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: miller_rabin_round_64.f
rtl/mrr_pkg.sv
rtl/mrr_if.sv
rtl/mrr_datapath.sv
rtl/mrr_ctrl.sv
rtl/miller_rabin_round_64.sv
tb/tb_mrr_checker.sv
tb/tb_miller_rabin_round_64.sv
